// ----- hw/rtl/timed_event_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Timed event queue: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_UNIT_MACROS_SVH
`define TIMED_EVENT_QUEUE_UNIT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define TEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define TEQ_NEVER(lbl, cond, msg) \
  `TEQ_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed event queue package
// Sizes, operation and status codes, sequencer states and record types.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned SLOT_COUNT = 64;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned CLASS_BITS = 4;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_POP    = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_EMPTY       = 2'd2,
    STAT_NOT_PENDING = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE,
    ST_WALK,
    ST_LINK_A,
    ST_LINK_B,
    ST_CAN,
    ST_POP,
    ST_REL,
    ST_RPT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]  tm;
    logic [CLASS_BITS-1:0] cls;
    logic [TAG_BITS-1:0]   tag;
  } slot_t;

  typedef struct packed {
    kind_e                 kind;
    logic [TIME_BITS-1:0]  event_time;
    logic [CLASS_BITS-1:0] event_class;
    logic [TAG_BITS-1:0]   action_tag;
    slot_idx_t             cancel_handle;
  } req_t;

  typedef struct packed {
    status_e              status;
    slot_idx_t            new_handle;
    logic [TIME_BITS-1:0] popped_time;
    logic [TAG_BITS-1:0]  popped_tag;
    logic [TIME_BITS-1:0] next_time;
    logic                 queue_empty;
  } rsp_t;

endpackage

// ----- hw/rtl/teq_if.sv -----
// ----------------------------------------------------------------------------
// Timed event queue channels
// Request and result channels with valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface teq_req_if;
  import teq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [TIME_BITS-1:0]  event_time;
  logic [CLASS_BITS-1:0] event_class;
  logic [TAG_BITS-1:0]   action_tag;
  logic [SLOT_W-1:0]     cancel_handle;

  modport source (
    output valid, kind, event_time, event_class, action_tag, cancel_handle,
    input  ready
  );
  modport sink (
    input  valid, kind, event_time, event_class, action_tag, cancel_handle,
    output ready
  );
endinterface

interface teq_rsp_if;
  import teq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    new_handle;
  logic [TIME_BITS-1:0] popped_time;
  logic [TAG_BITS-1:0]  popped_tag;
  logic [TIME_BITS-1:0] next_time;
  logic                 queue_empty;

  modport source (
    output valid, status, new_handle, popped_time, popped_tag, next_time, queue_empty,
    input  ready
  );
  modport sink (
    input  valid, status, new_handle, popped_time, popped_tag, next_time, queue_empty,
    output ready
  );
endinterface

// ----- hw/rtl/teq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/teq_cmp.sv -----
// ----------------------------------------------------------------------------
// Timed event queue order compare
// Tells whether a stored event sorts at or before the event being placed.
// ----------------------------------------------------------------------------
module teq_cmp (
  input  logic [teq_pkg::TIME_BITS-1:0]  slot_time_i,
  input  logic [teq_pkg::CLASS_BITS-1:0] slot_class_i,
  input  logic [teq_pkg::TIME_BITS-1:0]  key_time_i,
  input  logic [teq_pkg::CLASS_BITS-1:0] key_class_i,
  output logic                           le_o
);
  import teq_pkg::*;

  logic time_lt;
  logic time_eq;

  assign time_lt = slot_time_i < key_time_i;
  assign time_eq = slot_time_i == key_time_i;
  // equal time and class: the stored event stays ahead (arrival order)
  assign le_o    = time_lt || (time_eq && (slot_class_i <= key_class_i));

endmodule

// ----- hw/rtl/timed_event_queue_unit.sv -----
// Order: schedule runs decode, free, a walk over n = 0..63 entries, link A, link B and
//   report; cancel and pop run decode, cancel or pop, release and report; full, empty,
//   bad handle and no-op run decode and report. One item at a time; the list walk reads one
//   slot per cycle through the shared order compare and the payload and link RAM read ports.
// Reset: control, counts, list pointers and pending flags cleared; link words of
//   unwritten slots read as the free chain, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Timed event queue unit
// Time-ordered event queue as a doubly linked list in slot RAMs with a free list.
// ----------------------------------------------------------------------------
`include "timed_event_queue_unit_macros.svh"

module timed_event_queue_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  teq_req_if.sink    req_i,
  teq_rsp_if.source  rsp_o
);
  import teq_pkg::*;

  // --------------------------------------------------------------------------
  // Sequencer and list state
  // --------------------------------------------------------------------------
  state_e          state_q, state_d;
  req_t            req_q, req_d;
  slot_idx_t       head_q, head_d;
  slot_idx_t       tail_q, tail_d;
  slot_idx_t       free_q, free_d;
  slot_idx_t       e_q, e_d;         // slot being inserted or released
  slot_idx_t       cur_q, cur_d;     // walk position
  slot_idx_t       prv_q, prv_d;     // last slot passed by the walk
  logic            has_prv_q, has_prv_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SLOT_COUNT-1:0] pend_q, pend_d;   // slot holds a pending event
  logic [SLOT_COUNT-1:0] nwr_q, nwr_d;     // next link written since reset
  logic            nrd_vld_q, nrd_vld_d;
  slot_idx_t       nrd_addr_q, nrd_addr_d;
  rsp_t            work_q, work_d;
  rsp_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;

  // RAM ports
  logic      pay_we, pay_re;
  slot_idx_t pay_waddr, pay_raddr;
  slot_t     pay_wdata, pay_rdata;
  logic      nxt_we, nxt_re;
  slot_idx_t nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
  logic      prv_we, prv_re;
  slot_idx_t prv_waddr, prv_raddr, prv_wdata, prv_rdata;

  slot_idx_t nxt_val;
  logic      le;
  logic      is_full;
  logic      walk_go;
  logic      out_free;
  logic      accept;

  // --------------------------------------------------------------------------
  // Storage: payload (time, class, tag), next links, prev links
  // --------------------------------------------------------------------------
  teq_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOT_COUNT)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .re_i    (pay_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  teq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (nxt_re),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  teq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (prv_re),
    .raddr_i (prv_raddr),
    .rdata_o (prv_rdata)
  );

  // Shared order compare: stored slot versus the event being placed
  teq_cmp u_cmp (
    .slot_time_i  (pay_rdata.tm),
    .slot_class_i (pay_rdata.cls),
    .key_time_i   (req_q.event_time),
    .key_class_i  (req_q.event_class),
    .le_o         (le)
  );

  // A never-written link still points to the following slot (free chain).
  assign nxt_val  = nrd_vld_q ? nxt_rdata : nrd_addr_q + SLOT_W'(1);
  assign is_full  = count_q == CNT_W'(SLOT_COUNT);
  // Keep walking while entries remain and the current one sorts at or before the key.
  assign walk_go  = (steps_q != count_q) && le;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign accept   = req_i.valid && req_i.ready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (req_q.kind)
          KIND_SCHED:  state_d = is_full ? ST_RPT : ST_FREE;
          KIND_CANCEL: state_d = pend_q[req_q.cancel_handle] ? ST_CAN : ST_RPT;
          KIND_POP:    state_d = (count_q == '0) ? ST_RPT : ST_POP;
          default:     state_d = ST_RPT;
        endcase
      end
      ST_FREE:   state_d = ST_WALK;
      ST_WALK:   state_d = walk_go ? ST_WALK : ST_LINK_A;
      ST_LINK_A: state_d = ST_LINK_B;
      ST_LINK_B: state_d = ST_RPT;
      ST_CAN:    state_d = ST_REL;
      ST_POP:    state_d = ST_REL;
      ST_REL:    state_d = ST_RPT;
      ST_RPT:    state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    req_d     = req_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    e_d       = e_q;
    cur_d     = cur_q;
    prv_d     = prv_q;
    has_prv_d = has_prv_q;
    steps_d   = steps_q;
    count_d   = count_q;
    pend_d    = pend_q;
    nwr_d     = nwr_q;
    work_d    = work_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    pay_we    = 1'b0;
    pay_waddr = e_q;
    pay_wdata = '{tm: req_q.event_time, cls: req_q.event_class, tag: req_q.action_tag};
    pay_re    = 1'b0;
    pay_raddr = head_q;
    nxt_we    = 1'b0;
    nxt_waddr = e_q;
    nxt_wdata = '0;
    nxt_re    = 1'b0;
    nxt_raddr = head_q;
    prv_we    = 1'b0;
    prv_waddr = e_q;
    prv_wdata = '0;
    prv_re    = 1'b0;
    prv_raddr = req_q.cancel_handle;

    // drop the held result once the sink takes it
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = '{kind:          kind_e'(req_i.kind),
                    event_time:    req_i.event_time,
                    event_class:   req_i.event_class,
                    action_tag:    req_i.action_tag,
                    cancel_handle: req_i.cancel_handle};
          work_d = '0;
        end
      end

      ST_DECODE: begin
        case (req_q.kind)
          KIND_SCHED: begin
            if (is_full) begin
              work_d.status = STAT_FULL;
            end else begin
              // take the free head: store the event, fetch its link
              e_d       = free_q;
              pay_we    = 1'b1;
              pay_waddr = free_q;
              nxt_re    = 1'b1;
              nxt_raddr = free_q;
            end
          end
          KIND_CANCEL: begin
            if (!pend_q[req_q.cancel_handle]) begin
              work_d.status = STAT_NOT_PENDING;
            end else begin
              e_d       = req_q.cancel_handle;
              nxt_re    = 1'b1;
              nxt_raddr = req_q.cancel_handle;
              prv_re    = 1'b1;
            end
          end
          KIND_POP: begin
            if (count_q == '0) begin
              work_d.status = STAT_EMPTY;
            end else begin
              e_d       = head_q;
              pay_re    = 1'b1;
              pay_raddr = head_q;
              nxt_re    = 1'b1;
              nxt_raddr = head_q;
            end
          end
          default: begin
          end
        endcase
      end

      ST_FREE: begin
        // advance the free list, start the walk at the head
        free_d    = nxt_val;
        pay_re    = 1'b1;
        pay_raddr = head_q;
        nxt_re    = 1'b1;
        nxt_raddr = head_q;
        cur_d     = head_q;
        steps_d   = '0;
        has_prv_d = 1'b0;
      end

      ST_WALK: begin
        if (walk_go) begin
          prv_d     = cur_q;
          has_prv_d = 1'b1;
          cur_d     = nxt_val;
          steps_d   = steps_q + CNT_W'(1);
          pay_re    = 1'b1;
          pay_raddr = nxt_val;
          nxt_re    = 1'b1;
          nxt_raddr = nxt_val;
        end
      end

      ST_LINK_A: begin
        // links of the new slot, head and tail
        nxt_we       = 1'b1;
        nxt_waddr    = e_q;
        nxt_wdata    = (steps_q != count_q) ? cur_q : '0;
        nwr_d[e_q]   = 1'b1;
        prv_we       = 1'b1;
        prv_waddr    = e_q;
        prv_wdata    = has_prv_q ? prv_q : '0;
        if (!has_prv_q) begin
          head_d = e_q;
        end
        if (steps_q == count_q) begin
          tail_d = e_q;
        end
      end

      ST_LINK_B: begin
        // neighbors point at the new slot
        if (has_prv_q) begin
          nxt_we       = 1'b1;
          nxt_waddr    = prv_q;
          nxt_wdata    = e_q;
          nwr_d[prv_q] = 1'b1;
        end
        if (steps_q != count_q) begin
          prv_we    = 1'b1;
          prv_waddr = cur_q;
          prv_wdata = e_q;
        end
        pend_d[e_q]       = 1'b1;
        count_d           = count_q + CNT_W'(1);
        work_d.new_handle = e_q;
      end

      ST_CAN: begin
        // unlink: prv_rdata is the predecessor, nxt_val the successor
        if (e_q == head_q) begin
          head_d = nxt_val;
        end else begin
          nxt_we           = 1'b1;
          nxt_waddr        = prv_rdata;
          nxt_wdata        = nxt_val;
          nwr_d[prv_rdata] = 1'b1;
        end
        if (e_q == tail_q) begin
          tail_d = prv_rdata;
        end else begin
          prv_we    = 1'b1;
          prv_waddr = nxt_val;
          prv_wdata = prv_rdata;
        end
      end

      ST_POP: begin
        head_d             = nxt_val;
        work_d.popped_time = pay_rdata.tm;
        work_d.popped_tag  = pay_rdata.tag;
      end

      ST_REL: begin
        // return the slot to the front of the free list
        nxt_we      = 1'b1;
        nxt_waddr   = e_q;
        nxt_wdata   = free_q;
        nwr_d[e_q]  = 1'b1;
        free_d      = e_q;
        pend_d[e_q] = 1'b0;
        count_d     = count_q - CNT_W'(1);
      end

      ST_RPT: begin
        pay_re    = 1'b1;
        pay_raddr = head_q;
      end

      ST_FIN: begin
        if (out_free) begin
          out_d             = work_q;
          out_d.next_time   = (count_q != '0) ? pay_rdata.tm : '0;
          out_d.queue_empty = count_q == '0;
          out_vld_d         = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // Link flag of the slot being read travels with the registered read data.
  assign nrd_vld_d  = nxt_re ? nwr_q[nxt_raddr] : nrd_vld_q;
  assign nrd_addr_d = nxt_re ? nxt_raddr : nrd_addr_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      free_q    <= '0;
      count_q   <= '0;
      pend_q    <= '0;
      nwr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      free_q    <= free_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      nwr_q     <= nwr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload and walk registers: no reset needed
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    e_q        <= e_d;
    cur_q      <= cur_d;
    prv_q      <= prv_d;
    has_prv_q  <= has_prv_d;
    steps_q    <= steps_d;
    nrd_vld_q  <= nrd_vld_d;
    nrd_addr_q <= nrd_addr_d;
    work_q     <= work_d;
    out_q      <= out_d;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign req_i.ready       = state_q == ST_IDLE;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.new_handle  = out_q.new_handle;
  assign rsp_o.popped_time = out_q.popped_time;
  assign rsp_o.popped_tag  = out_q.popped_tag;
  assign rsp_o.next_time   = out_q.next_time;
  assign rsp_o.queue_empty = out_q.queue_empty;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TEQ_NEVER(a_count_bound, count_q > CNT_W'(SLOT_COUNT), "pending count above slot count")
  `TEQ_ASSERT(a_count_pend, CNT_W'($countones(pend_q)) == count_q, "pending flags disagree with count")
  `TEQ_ASSERT(a_head_pend, (state_q == ST_IDLE && count_q != '0) |-> pend_q[head_q], "head slot not pending")
  `TEQ_NEVER(a_walk_bound, state_q == ST_WALK && steps_q > count_q, "walk ran past list end")

endmodule
